/* rtl/core/stk_pkg.sv */
`timescale 1ns / 1ps

package stk_pkg;

  localparam int MAX_ATOM   = 256;
  localparam int MAX_STRING = 255;
  localparam int LEN_W      = 9;

  localparam logic [LEN_W-1:0] ATOM_KEEP = LEN_W'(MAX_ATOM - 1);
  localparam logic [LEN_W-1:0] STR_KEEP  = LEN_W'(MAX_STRING);

  // scanner modes
  localparam logic [1:0] MODE_IDLE    = 2'd0;
  localparam logic [1:0] MODE_COMMENT = 2'd1;
  localparam logic [1:0] MODE_ATOM    = 2'd2;
  localparam logic [1:0] MODE_STRING  = 2'd3;

  // result kinds
  localparam logic [3:0] K_ATOM_CHAR   = 4'd0;
  localparam logic [3:0] K_STRING_CHAR = 4'd1;
  localparam logic [3:0] K_SYMBOL_END  = 4'd2;
  localparam logic [3:0] K_NUMBER_END  = 4'd3;
  localparam logic [3:0] K_STRING_END  = 4'd4;
  localparam logic [3:0] K_LPAREN      = 4'd5;
  localparam logic [3:0] K_RPAREN      = 4'd6;
  localparam logic [3:0] K_QUOTE       = 4'd7;
  localparam logic [3:0] K_DOT         = 4'd8;

  // characters
  localparam logic [7:0] C_SPACE  = 8'h20;
  localparam logic [7:0] C_TAB    = 8'h09;
  localparam logic [7:0] C_NL     = 8'h0A;
  localparam logic [7:0] C_SEMI   = 8'h3B;
  localparam logic [7:0] C_DQUOTE = 8'h22;
  localparam logic [7:0] C_QUOTE  = 8'h27;
  localparam logic [7:0] C_LPAR   = 8'h28;
  localparam logic [7:0] C_RPAR   = 8'h29;
  localparam logic [7:0] C_DOT    = 8'h2E;
  localparam logic [7:0] C_PLUS   = 8'h2B;
  localparam logic [7:0] C_MINUS  = 8'h2D;
  localparam logic [7:0] C_E      = 8'h65;
  localparam logic [7:0] C_ZERO   = 8'h30;
  localparam logic [7:0] C_NINE   = 8'h39;
  localparam logic [7:0] C_UP_A   = 8'h41;
  localparam logic [7:0] C_UP_Z   = 8'h5A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  // queue between front and back
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef struct packed {
    logic [3:0] kind;
    logic [7:0] char_value;
    logic       truncated;
    logic       last;
  } result_t;

  // one input byte's worth of results: r0 always, r1 when two is set
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

endpackage

/* rtl/core/stk_front.sv */
`timescale 1ns / 1ps

module stk_front (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic [7:0]      ch,
  input  logic            q_ready,
  output logic            push,
  output stk_pkg::entry_t push_entry
);
  import stk_pkg::*;

  logic [1:0]       mode, mode_next;
  logic [LEN_W-1:0] len, len_next;
  logic [7:0]       prev, prev_next;
  logic             nok, nok_next;
  logic             sexp, sexp_next;
  logic             spt, spt_next;
  logic             fsign, fsign_next;
  logic             dropped, dropped_next;

  logic             fire;
  logic [7:0]       lc;
  logic             is_sep, is_tok;
  logic [3:0]       tok_kind;
  logic             in_atom;
  logic [LEN_W-1:0] b_len;
  logic [7:0]       b_prev;
  logic             b_nok, b_sexp, b_spt, b_fsign;
  logic             ab_nok, ab_sexp, ab_spt, ab_fsign;
  logic             keep;
  logic             num;
  logic             has_res;
  entry_t           e;

  assign in_ready = q_ready;
  assign fire     = in_valid && in_ready;

  always_comb begin
    lc = ((ch >= C_UP_A) && (ch <= C_UP_Z)) ? ch + CASE_OFS : ch;
    is_sep = (ch == C_SPACE) || (ch == C_TAB) || (ch == C_NL);
    is_tok = 1'b1;
    tok_kind = K_LPAREN;
    if (ch == C_LPAR) begin
      tok_kind = K_LPAREN;
    end else if (ch == C_RPAR) begin
      tok_kind = K_RPAREN;
    end else if (ch == C_QUOTE) begin
      tok_kind = K_QUOTE;
    end else begin
      is_tok = 1'b0;
    end

    // atom state as seen by this byte; a fresh atom starts from cleared state
    in_atom = (mode == MODE_ATOM);
    b_len   = in_atom ? len : '0;
    b_prev  = in_atom ? prev : 8'd0;
    b_nok   = in_atom ? nok : 1'b1;
    b_sexp  = in_atom ? sexp : 1'b0;
    b_spt   = in_atom ? spt : 1'b0;
    b_fsign = in_atom ? fsign : 1'b0;
    keep    = (b_len < ATOM_KEEP);

    ab_nok   = b_nok;
    ab_sexp  = b_sexp;
    ab_spt   = b_spt;
    ab_fsign = b_fsign;
    if ((lc == C_PLUS) || (lc == C_MINUS)) begin
      if (b_len == '0) ab_fsign = 1'b1;
      else if (b_prev != C_E) ab_nok = 1'b0;
    end else if (lc == C_E) begin
      if ((b_len == '0) || b_sexp) ab_nok = 1'b0;
      ab_sexp = 1'b1;
    end else if (lc == C_DOT) begin
      if (b_spt) ab_nok = 1'b0;
      ab_spt = 1'b1;
    end else if ((lc < C_ZERO) || (lc > C_NINE)) begin
      ab_nok = 1'b0;
    end

    num = nok && !((len == LEN_W'(1)) && fsign);

    mode_next    = mode;
    len_next     = len;
    prev_next    = prev;
    nok_next     = nok;
    sexp_next    = sexp;
    spt_next     = spt;
    fsign_next   = fsign;
    dropped_next = dropped;
    has_res      = 1'b0;
    e            = '0;

    unique case (mode)
      MODE_COMMENT: begin
        if (ch == C_NL) mode_next = MODE_IDLE;
      end
      MODE_STRING: begin
        if (ch == C_DQUOTE) begin
          has_res = 1'b1;
          e.r0 = '{kind: K_STRING_END, char_value: 8'd0, truncated: dropped, last: 1'b1};
          mode_next    = MODE_IDLE;
          len_next     = '0;
          prev_next    = 8'd0;
          nok_next     = 1'b1;
          sexp_next    = 1'b0;
          spt_next     = 1'b0;
          fsign_next   = 1'b0;
          dropped_next = 1'b0;
        end else if (len >= STR_KEEP) begin
          dropped_next = 1'b1;
        end else begin
          has_res  = 1'b1;
          len_next = len + LEN_W'(1);
          e.r0 = '{kind: K_STRING_CHAR, char_value: ch, truncated: 1'b0, last: 1'b1};
        end
      end
      MODE_ATOM: begin
        if (is_sep || is_tok) begin
          has_res = 1'b1;
          e.two   = is_tok;
          e.r0 = '{kind: num ? K_NUMBER_END : K_SYMBOL_END, char_value: 8'd0,
                   truncated: dropped, last: !is_tok};
          e.r1 = '{kind: tok_kind, char_value: 8'd0, truncated: 1'b0, last: 1'b1};
          mode_next    = MODE_IDLE;
          len_next     = '0;
          prev_next    = 8'd0;
          nok_next     = 1'b1;
          sexp_next    = 1'b0;
          spt_next     = 1'b0;
          fsign_next   = 1'b0;
          dropped_next = 1'b0;
        end else if (!keep) begin
          dropped_next = 1'b1;
        end else begin
          has_res    = 1'b1;
          e.r0 = '{kind: K_ATOM_CHAR, char_value: lc, truncated: 1'b0, last: 1'b1};
          len_next   = len + LEN_W'(1);
          prev_next  = lc;
          nok_next   = ab_nok;
          sexp_next  = ab_sexp;
          spt_next   = ab_spt;
          fsign_next = ab_fsign;
        end
      end
      MODE_IDLE: begin
        if (is_sep) begin
          mode_next = MODE_IDLE;
        end else if (ch == C_SEMI) begin
          mode_next = MODE_COMMENT;
        end else if (is_tok || (ch == C_DOT)) begin
          has_res = 1'b1;
          e.r0 = '{kind: is_tok ? tok_kind : K_DOT, char_value: 8'd0,
                   truncated: 1'b0, last: 1'b1};
        end else if (ch == C_DQUOTE) begin
          mode_next    = MODE_STRING;
          len_next     = '0;
          prev_next    = 8'd0;
          nok_next     = 1'b1;
          sexp_next    = 1'b0;
          spt_next     = 1'b0;
          fsign_next   = 1'b0;
          dropped_next = 1'b0;
        end else begin
          // first atom byte is always kept
          mode_next    = MODE_ATOM;
          has_res      = 1'b1;
          e.r0 = '{kind: K_ATOM_CHAR, char_value: lc, truncated: 1'b0, last: 1'b1};
          len_next     = LEN_W'(1);
          prev_next    = lc;
          nok_next     = ab_nok;
          sexp_next    = ab_sexp;
          spt_next     = ab_spt;
          fsign_next   = ab_fsign;
          dropped_next = 1'b0;
        end
      end
    endcase
  end

  assign push       = fire && has_res;
  assign push_entry = e;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode    <= MODE_IDLE;
      len     <= '0;
      prev    <= 8'd0;
      nok     <= 1'b1;
      sexp    <= 1'b0;
      spt     <= 1'b0;
      fsign   <= 1'b0;
      dropped <= 1'b0;
    end else if (fire) begin
      mode    <= mode_next;
      len     <= len_next;
      prev    <= prev_next;
      nok     <= nok_next;
      sexp    <= sexp_next;
      spt     <= spt_next;
      fsign   <= fsign_next;
      dropped <= dropped_next;
    end
  end

  // token state is clear whenever the scanner sits between tokens
  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_IDLE) |-> (len == '0 && !dropped))
    else $error("token state not cleared between tokens");

  // string length never passes its cap
  a_str_cap: assert property (@(posedge clk) disable iff (rst)
    (mode == MODE_STRING) |-> (len <= STR_KEEP))
    else $error("string length beyond cap");

endmodule

/* rtl/core/stk_queue.sv */
`timescale 1ns / 1ps

module stk_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  stk_pkg::entry_t push_entry,
  output logic            q_ready,
  input  logic            pop,
  output logic            q_valid,
  output stk_pkg::entry_t pop_entry
);
  import stk_pkg::*;

  entry_t            mem [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;
  logic              do_push, do_pop;

  assign q_ready   = (count != QCNT_W'(QDEPTH));
  assign q_valid   = (count != '0);
  assign do_push   = push && q_ready;
  assign do_pop    = pop && q_valid;
  assign pop_entry = mem[rptr];

  always_ff @(posedge clk) begin
    if (do_push) mem[wptr] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_push) wptr <= wptr + QPTR_W'(1);
      if (do_pop) rptr <= rptr + QPTR_W'(1);
      unique case ({do_push, do_pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> q_ready)
    else $error("push into full queue");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= QCNT_W'(QDEPTH))
    else $error("queue count out of range");

endmodule

/* rtl/core/stk_back.sv */
`timescale 1ns / 1ps

module stk_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            q_valid,
  input  stk_pkg::entry_t pop_entry,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output stk_pkg::result_t out_res
);
  import stk_pkg::*;

  logic    cur_valid;
  result_t cur;
  logic    pend;
  result_t pend_res;
  logic    adv;

  // output slot frees when empty or being taken this cycle
  assign adv       = !cur_valid || out_ready;
  assign pop       = adv && !pend && q_valid;
  assign out_valid = cur_valid;
  assign out_res   = cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      pend      <= 1'b0;
    end else if (adv) begin
      if (pend) begin
        cur_valid <= 1'b1;
        pend      <= 1'b0;
      end else begin
        cur_valid <= q_valid;
        pend      <= q_valid && pop_entry.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (pend) begin
        cur <= pend_res;
      end else if (q_valid) begin
        cur      <= pop_entry.r0;
        pend_res <= pop_entry.r1;
      end
    end
  end

  a_pend_behind_out: assert property (@(posedge clk) disable iff (rst)
    pend |-> cur_valid)
    else $error("second result pending with empty output");

  a_not_last_pend: assert property (@(posedge clk) disable iff (rst)
    (cur_valid && !cur.last) |-> pend)
    else $error("non-final result without follower");

endmodule

/* rtl/core/sexpr_token_scanner.sv */
`timescale 1ns / 1ps
// Channel   Handshake              Payload
// input     in_valid / in_ready    ch[7:0]
// output    out_valid / out_ready  kind[3:0], char_value[7:0], truncated, last
//
// One byte is accepted per cycle while the 4-entry queue has room; a byte
// with two results holds the output for each result in turn, so the sustained
// rate is one byte per cycle while out_ready is high, save for atoms ended by
// a one-char token. A byte's earliest result is written into the queue when the
// byte transfers and is then loaded into the output register.
// rst is synchronous, active high; it returns the scanner to between tokens
// and empties the queue. Output stalls back up through the queue to in_ready.

module sexpr_token_scanner (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] kind,
  output logic [7:0] char_value,
  output logic       truncated,
  output logic       last
);
  import stk_pkg::*;

  logic    q_ready, q_valid, push, pop;
  entry_t  push_entry, pop_entry;
  result_t out_res;

  stk_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .ch         (ch),
    .q_ready    (q_ready),
    .push       (push),
    .push_entry (push_entry)
  );

  stk_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .q_valid    (q_valid),
    .pop_entry  (pop_entry)
  );

  stk_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .pop_entry (pop_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign kind       = out_res.kind;
  assign char_value = out_res.char_value;
  assign truncated  = out_res.truncated;
  assign last       = out_res.last;

endmodule

/* bench/testbench.sv */
`timescale 1ns / 1ps

module testbench;
  import stk_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 12;
  localparam int MAX_WAIT       = 17;

  // how random atom text is built
  localparam int STYLE_SYMBOL  = 0;
  localparam int STYLE_NUMERIC = 1;
  localparam int STYLE_DIGITS  = 2;

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic [7:0] ch        = '0;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [3:0] kind;
  logic [7:0] char_value;
  logic       truncated;
  logic       last;

  sexpr_token_scanner dut (.*);

  initial forever #4 clk = ~clk;

  // scanner state as the predictor tracks it
  logic [1:0]       scan_mode;
  logic [LEN_W-1:0] tok_len;
  logic [7:0]       prev_kept;
  logic             num_ok;
  logic             saw_exp;
  logic             saw_point;
  logic             lead_sign;
  logic             dropped;

  result_t expected_tokens [$];
  int      errors         = 0;
  int      sent_bytes     = 0;
  int      send_gap_max   = MAX_WAIT;
  int      recv_stall_max = MAX_WAIT;
  int      idle_cycles    = 0;

  function automatic result_t token_result(logic [3:0] k, logic [7:0] v, logic t, logic l);
    result_t r;
    r.kind       = k;
    r.char_value = v;
    r.truncated  = t;
    r.last       = l;
    return r;
  endfunction

  function automatic logic is_space(logic [7:0] c);
    return c == C_SPACE || c == C_TAB || c == C_NL;
  endfunction

  function automatic logic [3:0] punct_kind(logic [7:0] c, logic at_start);
    if (c == C_LPAR) return K_LPAREN;
    if (c == C_RPAR) return K_RPAREN;
    if (c == C_QUOTE) return K_QUOTE;
    if (c == C_DOT && at_start) return K_DOT;
    return K_ATOM_CHAR;  // not a one-char token
  endfunction

  task automatic clear_token();
    tok_len   = '0;
    prev_kept = '0;
    num_ok    = 1'b1;
    saw_exp   = 1'b0;
    saw_point = 1'b0;
    lead_sign = 1'b0;
    dropped   = 1'b0;
  endtask

  task automatic keep_atom_byte(logic [7:0] c);
    logic [7:0] lc;
    lc = c;
    if (tok_len >= ATOM_KEEP) begin
      dropped = 1'b1;
      return;
    end
    if (lc >= C_UP_A && lc <= C_UP_Z) lc = lc + CASE_OFS;
    if (lc == C_PLUS || lc == C_MINUS) begin
      if (tok_len == 0) lead_sign = 1'b1;
      else if (prev_kept != C_E) num_ok = 1'b0;
    end else if (lc == C_E) begin
      if (tok_len == 0 || saw_exp) num_ok = 1'b0;
      saw_exp = 1'b1;
    end else if (lc == C_DOT) begin
      if (saw_point) num_ok = 1'b0;
      saw_point = 1'b1;
    end else if (lc < C_ZERO || lc > C_NINE) begin
      num_ok = 1'b0;
    end
    prev_kept = lc;
    tok_len++;
    expected_tokens.push_back(token_result(K_ATOM_CHAR, lc, 1'b0, 1'b1));
  endtask

  // advance the scanner by one byte and queue the results it must give
  task automatic scan_byte(logic [7:0] c);
    logic [3:0] tk;
    logic       is_num;
    case (scan_mode)
      MODE_COMMENT: begin
        if (c == C_NL) scan_mode = MODE_IDLE;
      end
      MODE_STRING: begin
        if (c == C_DQUOTE) begin
          expected_tokens.push_back(token_result(K_STRING_END, 8'h00, dropped, 1'b1));
          scan_mode = MODE_IDLE;
          clear_token();
        end else if (tok_len >= STR_KEEP) begin
          dropped = 1'b1;
        end else begin
          tok_len++;
          expected_tokens.push_back(token_result(K_STRING_CHAR, c, 1'b0, 1'b1));
        end
      end
      MODE_ATOM: begin
        tk = punct_kind(c, 1'b0);
        if (is_space(c) || tk != K_ATOM_CHAR) begin
          // a lone sign is a symbol
          is_num = num_ok && !(tok_len == 1 && lead_sign);
          expected_tokens.push_back(token_result(is_num ? K_NUMBER_END : K_SYMBOL_END,
                                                 8'h00, dropped, tk == K_ATOM_CHAR));
          scan_mode = MODE_IDLE;
          clear_token();
          if (tk != K_ATOM_CHAR)
            expected_tokens.push_back(token_result(tk, 8'h00, 1'b0, 1'b1));
        end else begin
          keep_atom_byte(c);
        end
      end
      default: begin
        tk = punct_kind(c, 1'b1);
        if (!is_space(c)) begin
          if (c == C_SEMI) begin
            scan_mode = MODE_COMMENT;
          end else if (tk != K_ATOM_CHAR) begin
            expected_tokens.push_back(token_result(tk, 8'h00, 1'b0, 1'b1));
          end else begin
            clear_token();
            if (c == C_DQUOTE) begin
              scan_mode = MODE_STRING;
            end else begin
              scan_mode = MODE_ATOM;
              keep_atom_byte(c);
            end
          end
        end
      end
    endcase
  endtask

  task automatic send_byte(logic [7:0] c);
    int gap;
    gap = $urandom_range(send_gap_max, 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    ch       <= c;
    do @(posedge clk); while (!in_ready);
    sent_bytes++;
    scan_byte(c);
  endtask

  function automatic logic [7:0] letter_char();
    logic [7:0] c;
    c = 8'($urandom_range(C_UP_Z, C_UP_A));
    if ($urandom_range(1, 0)) c = c + CASE_OFS;
    return c;
  endfunction

  // any byte that does not end an atom
  function automatic logic [7:0] symbol_char();
    logic [7:0] c;
    do c = 8'($urandom_range(255, 0));
    while (is_space(c) || c == C_LPAR || c == C_RPAR || c == C_QUOTE);
    return c;
  endfunction

  function automatic logic [7:0] numeric_char();
    int r;
    r = $urandom_range(19, 0);
    if (r == 12) return C_E;
    if (r == 13) return C_E - CASE_OFS;
    if (r == 14) return C_DOT;
    if (r == 15) return C_PLUS;
    if (r == 16) return C_MINUS;
    if (r == 17) return symbol_char();
    return C_ZERO + 8'($urandom_range(9, 0));
  endfunction

  function automatic logic [7:0] end_char();
    case ($urandom_range(5, 0))
      0:       return C_SPACE;
      1:       return C_TAB;
      2:       return C_NL;
      3:       return C_LPAR;
      4:       return C_RPAR;
      default: return C_QUOTE;
    endcase
  endfunction

  function automatic logic [7:0] string_char();
    logic [7:0] c;
    c = 8'($urandom_range(254, 0));
    if (c >= C_DQUOTE) c = c + 8'd1;
    return c;
  endfunction

  // atom body only; past the keep limit the bytes are symbol chars
  task automatic send_atom(int n, int style);
    logic [7:0] c;
    for (int i = 0; i < n; i++) begin
      if (i >= int'(ATOM_KEEP)) c = symbol_char();
      else if (style == STYLE_SYMBOL) c = (i == 0) ? letter_char() : symbol_char();
      else if (style == STYLE_DIGITS) c = C_ZERO + 8'($urandom_range(9, 0));
      else if (i == 0) c = ($urandom_range(3, 0) == 0) ? C_MINUS
                                                       : C_ZERO + 8'($urandom_range(9, 0));
      else c = numeric_char();
      send_byte(c);
    end
  endtask

  task automatic send_string(int n);
    send_byte(C_DQUOTE);
    repeat (n) send_byte(string_char());
    send_byte(C_DQUOTE);
  endtask

  task automatic send_random_token();
    int r;
    r = $urandom_range(99, 0);
    if (r < 15) begin
      case ($urandom_range(3, 0))
        0:       send_byte(C_LPAR);
        1:       send_byte(C_RPAR);
        2:       send_byte(C_QUOTE);
        default: send_byte(C_DOT);
      endcase
    end else if (r < 28) begin
      repeat ($urandom_range(3, 1)) send_byte(end_char() == C_SPACE ? C_SPACE : C_TAB);
      if ($urandom_range(1, 0)) send_byte(C_NL);
    end else if (r < 62) begin
      send_atom($urandom_range(8, 1), $urandom_range(1, 0) ? STYLE_NUMERIC : STYLE_SYMBOL);
      send_byte(end_char());
    end else if (r < 78) begin
      send_string($urandom_range(10, 0));
    end else if (r < 85) begin
      send_byte(C_SEMI);
      repeat ($urandom_range(8, 0)) send_byte(string_char() == C_NL ? C_SPACE : symbol_char());
      send_byte(C_NL);
    end else begin
      send_byte(8'($urandom_range(255, 0)));
    end
  endtask

  task automatic test_directed();
    logic [7:0] seq [29];
    seq = '{C_LPAR, C_RPAR, C_QUOTE, C_DOT, C_SPACE, C_TAB, C_NL,
            C_SEMI, C_LPAR, C_NL,                           // comment hides the paren
            C_DQUOTE, C_UP_A, 8'hFF, C_DQUOTE,              // string keeps case
            C_PLUS, C_SPACE,                                // lone sign
            C_MINUS, 8'h31, 8'h45, C_MINUS, 8'h32, C_LPAR,  // -1E-2 then paren
            8'h00, C_DOT, C_DQUOTE, C_SEMI, C_RPAR,         // odd bytes inside an atom
            8'h37, C_QUOTE};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_random_text(int n_bytes, int gap_max, int stall_max);
    int stop_at;
    send_gap_max   = gap_max;
    recv_stall_max = stall_max;
    stop_at        = sent_bytes + n_bytes;
    while (sent_bytes < stop_at) send_random_token();
  endtask

  // keep limits: one byte over, so the last kept and the first dropped byte both occur
  task automatic test_long_tokens();
    send_gap_max   = MAX_WAIT;
    recv_stall_max = MAX_WAIT;
    send_atom(int'(ATOM_KEEP) + 1, STYLE_DIGITS);
    send_byte(C_RPAR);
    send_string(MAX_STRING + 1);
  endtask

  // result sink with random stalls
  initial begin
    int stall;
    @(negedge rst);
    forever begin
      stall = $urandom_range(recv_stall_max, 0);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (expected_tokens.size() == 0) begin
          $error("unexpected result: kind %0d char_value %0h", kind, char_value);
          errors++;
        end else begin
          want = expected_tokens.pop_front();
          if (kind !== want.kind) begin
            $error("kind: expected %0d, got %0d", want.kind, kind);
            errors++;
          end
          if (char_value !== want.char_value) begin
            $error("char_value: expected %0h, got %0h", want.char_value, char_value);
            errors++;
          end
          if (truncated !== want.truncated) begin
            $error("truncated: expected %0b, got %0b", want.truncated, truncated);
            errors++;
          end
          if (last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, last);
            errors++;
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    scan_mode = MODE_IDLE;
    clear_token();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_random_text(150, MAX_WAIT, MAX_WAIT);
    test_random_text(100, 0, 0);
    test_random_text(100, 0, MAX_WAIT);
    test_random_text(100, MAX_WAIT, 0);
    test_long_tokens();
    in_valid <= 1'b0;
    while (expected_tokens.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
